@@ rtl/core/spmv_pkg.sv @@
`timescale 1ns / 1ps
package spmv_pkg;

  localparam int ROWS       = 1024;
  localparam int COLS       = 1024;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 10;
  localparam int CFG_W      = 11;
  localparam int VAL_W      = 32;
  localparam int SEEN_W     = 32;
  localparam int SEEN_BW    = 5;
  localparam int SEEN_WORDS = ROWS / SEEN_W;
  localparam int SEEN_AW    = ROW_W - SEEN_BW;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;

  localparam int DEF_MAX_NONZEROS = 4096;

  localparam logic [CFG_W-1:0] ROW_COUNT_RST    = 11'd1024;
  localparam logic [CFG_W-1:0] COLUMN_COUNT_RST = 11'd1024;

  // command codes
  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_LOAD_NZ = 3'd1;
  localparam logic [2:0] CMD_LOAD_X  = 3'd2;
  localparam logic [2:0] CMD_LOAD_Y  = 3'd3;
  localparam logic [2:0] CMD_COMPUTE = 3'd4;

  // configuration register indexes
  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  localparam logic [VAL_W-1:0] FP_ZERO = 32'h0000_0000;
  localparam logic [VAL_W-1:0] FP_QNAN = 32'hFFC0_0000;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] column_index;
    logic [VAL_W-1:0] entry_value;
  } spmv_in_t;

  typedef struct packed {
    logic [ROW_W-1:0] result_row;
    logic [VAL_W-1:0] result_value;
    logic             bad_request;
  } spmv_out_t;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_NZ,
    OP_LDX,
    OP_LDY,
    OP_ROW,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] column_index;
    logic [VAL_W-1:0] entry_value;
  } spmv_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_NZ_SEEN,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_START_GOT,
    ST_ELEM_CHK,
    ST_ELEM_RD,
    ST_X_RD,
    ST_MUL_WAIT,
    ST_ADD_WAIT,
    ST_Y_RD,
    ST_SUM_WAIT,
    ST_EMIT
  } back_state_t;

endpackage

@@ rtl/core/csr_sparse_matrix_vector_multiply_top.sv @@
`timescale 1ns / 1ps
// Channel   Ports                                  Moves
// input     push, full, in_word                    one command word
// result    empty, pop, out_word                   one result word
// config    cfg_we, cfg_index, cfg_data            row or column count
//
// Loads and clears are handled in the execute engine; a store full
// or out-of-range request yields a refused result word for hand-over.
// A compute request scans the seen map one 32-row word at a time
// (twice: row start and row end), then takes each nonzero in turn
// (memory reads, 3-stage multiplier, 3-stage adder in series).
// The accumulation chain through the adder keeps the nonzeros in series.
// Reset is synchronous; no memory sweep is needed afterwards.
// A 4-word queue holds commands while the engine works or waits on pop.
module csr_sparse_matrix_vector_multiply_top #(
  parameter int MAX_NONZEROS = spmv_pkg::DEF_MAX_NONZEROS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  spmv_pkg::spmv_in_t  in_word,
  output logic                empty,
  input  logic                pop,
  output spmv_pkg::spmv_out_t out_word,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [10:0]         cfg_data
);
  import spmv_pkg::*;

  logic      q_pop, q_empty;
  spmv_cmd_t q_head;

  // front: take words, drop no-ops, flag range faults, queue the rest
  spmv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_pop     (q_pop),
    .q_empty   (q_empty),
    .q_head    (q_head)
  );

  // back: hold the matrix, walk rows, accumulate, present results
  spmv_back #(
    .MAX_NONZEROS (MAX_NONZEROS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

`ifndef SYNTHESIS
  a_reset_clean : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> (empty && !full))
    else $error("queues not clear after reset");

  a_bad_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_word.bad_request) |-> (out_word.result_value == FP_ZERO))
    else $error("refused request carries a value");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("engine took from an empty queue");
`endif

endmodule

@@ rtl/core/spmv_front.sv @@
`timescale 1ns / 1ps
module spmv_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  spmv_pkg::spmv_in_t   in_word,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [10:0]          cfg_data,
  input  logic                 q_pop,
  output logic                 q_empty,
  output spmv_pkg::spmv_cmd_t  q_head
);
  import spmv_pkg::*;

  logic [CFG_W-1:0] row_count_r;
  logic [CFG_W-1:0] column_count_r;
  spmv_cmd_t        q_mem [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]    cnt_r;
  logic             keep;
  op_t              op;
  logic             row_ok, col_ok, enq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= ROW_COUNT_RST;
      column_count_r <= COLUMN_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    row_count_r    <= cfg_data;
        REG_COLUMN_COUNT: column_count_r <= cfg_data;
        default:          row_count_r    <= row_count_r;
      endcase
    end
  end

  // classify: drop what has no effect, flag what is refused
  always_comb begin
    row_ok = {1'b0, in_word.row_index} < row_count_r;
    col_ok = {1'b0, in_word.column_index} < column_count_r;
    keep   = 1'b0;
    op     = OP_CLEAR;
    case (in_word.cmd)
      CMD_CLEAR: begin
        keep = 1'b1;
        op   = OP_CLEAR;
      end
      CMD_LOAD_NZ: begin
        keep = 1'b1;
        op   = (row_ok && col_ok) ? OP_NZ : OP_BAD;
      end
      CMD_LOAD_X: begin
        keep = col_ok;
        op   = OP_LDX;
      end
      CMD_LOAD_Y: begin
        keep = row_ok;
        op   = OP_LDY;
      end
      CMD_COMPUTE: begin
        keep = 1'b1;
        op   = row_ok ? OP_ROW : OP_BAD;
      end
      default: begin
        keep = 1'b0;
        op   = OP_CLEAR;
      end
    endcase
  end

  assign full    = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign enq     = push && !full && keep;
  assign q_head  = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem[wr_ptr_r] <= '{op: op, row_index: in_word.row_index,
                           column_index: in_word.column_index,
                           entry_value: in_word.entry_value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (enq) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (Q_AW+1)'(enq) - (Q_AW+1)'(q_pop);
    end
  end

endmodule

@@ rtl/core/spmv_fpmul.sv @@
`timescale 1ns / 1ps
module spmv_fpmul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] y
);
  import spmv_pkg::*;

  logic        v1_r, v2_r, v3_r;
  logic [47:0] p1_r, p2_r;
  logic [8:0]  e1_r, e2_r;
  logic        s1_r, s2_r, sp1_r, sp2_r;
  logic [31:0] spv1_r, spv2_r, y_r;
  logic [5:0]  lz2_nxt;

  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sgn;
  logic        sp;
  logic [31:0] spv;

  always_comb begin
    ea     = a[30:23];
    eb     = b[30:23];
    ma     = {ea != 8'd0, a[22:0]};
    mb     = {eb != 8'd0, b[22:0]};
    nan_a  = (ea == 8'hFF) && (a[22:0] != '0);
    nan_b  = (eb == 8'hFF) && (b[22:0] != '0);
    inf_a  = (ea == 8'hFF) && (a[22:0] == '0);
    inf_b  = (eb == 8'hFF) && (b[22:0] == '0);
    zero_a = (a[30:0] == '0);
    zero_b = (b[30:0] == '0);
    sgn    = a[31] ^ b[31];
    sp     = 1'b1;
    priority if (nan_a)                              spv = a | 32'h0040_0000;
    else if (nan_b)                                  spv = b | 32'h0040_0000;
    else if ((inf_a && zero_b) || (inf_b && zero_a)) spv = FP_QNAN;
    else if (inf_a || inf_b)                         spv = {sgn, 8'hFF, 23'd0};
    else if (zero_a || zero_b)                       spv = {sgn, 31'd0};
    else begin
      sp  = 1'b0;
      spv = FP_ZERO;
    end
  end

  // stage 1: significand product
  always_ff @(posedge clk) begin
    p1_r   <= ma * mb;
    e1_r   <= 9'((ea == 8'd0) ? 8'd1 : ea) + 9'((eb == 8'd0) ? 8'd1 : eb);
    s1_r   <= sgn;
    sp1_r  <= sp;
    spv1_r <= spv;
  end

  // stage 2: leading zero count
  always_comb begin
    lz2_nxt = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (p1_r[i]) lz2_nxt = 6'(47 - i);
    end
  end

  logic [5:0] lz2_r;
  always_ff @(posedge clk) begin
    p2_r   <= p1_r;
    lz2_r  <= lz2_nxt;
    e2_r   <= e1_r;
    s2_r   <= s1_r;
    sp2_r  <= sp1_r;
    spv2_r <= spv1_r;
  end

  // stage 3: shift into place and round to nearest even
  logic signed [10:0] exp_s, left_s;
  logic [7:0]         efld;
  logic [5:0]         lsh;
  logic [7:0]         rsh;
  logic [47:0]        n;
  logic               st_rs, g, st, up;
  logic [30:0]        rnd;
  logic [31:0]        y_nxt;

  always_comb begin
    exp_s  = $signed({2'b0, e2_r}) - 11'sd126 - $signed({5'b0, lz2_r});
    left_s = $signed({5'b0, lz2_r}) + exp_s - 11'sd1;
    lsh    = '0;
    rsh    = '0;
    efld   = '0;
    if (exp_s >= 11'sd1) begin
      efld = exp_s[7:0];
      lsh  = lz2_r;
    end else if (left_s >= 11'sd0) begin
      lsh = left_s[5:0];
    end else begin
      rsh = (left_s < -11'sd63) ? 8'd63 : 8'(-left_s);
    end
    n     = p2_r << lsh;
    st_rs = 1'b0;
    if (rsh >= 8'd48) begin
      st_rs = (n != '0);
      n     = '0;
    end else if (rsh != 8'd0) begin
      st_rs = ((n & ~({48{1'b1}} << rsh)) != '0);
      n     = n >> rsh;
    end
    g   = n[23];
    st  = (n[22:0] != '0) | st_rs;
    up  = g & (st | n[24]);
    rnd = {efld, n[46:24]} + 31'(up);
    priority if (sp2_r)             y_nxt = spv2_r;
    else if (exp_s >= 11'sd255)     y_nxt = {s2_r, 8'hFF, 23'd0};
    else                            y_nxt = {s2_r, rnd};
  end

  always_ff @(posedge clk) begin
    y_r <= y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign done = v3_r;
  assign y    = y_r;

endmodule

@@ rtl/core/spmv_fpadd.sv @@
`timescale 1ns / 1ps
module spmv_fpadd (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] y
);
  import spmv_pkg::*;

  logic        v1_r, v2_r, v3_r;

  // stage 1: order by magnitude and align
  logic [31:0] big, sml;
  logic [7:0]  eb_eff, es_eff, d;
  logic [26:0] xa, yb, ysh;
  logic        ysticky;
  logic        nan_a, nan_b, inf_a, inf_b, sp;
  logic [31:0] spv;

  always_comb begin
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    sp    = 1'b1;
    priority if (nan_a)                       spv = a | 32'h0040_0000;
    else if (nan_b)                           spv = b | 32'h0040_0000;
    else if (inf_a && inf_b && (a[31] != b[31])) spv = FP_QNAN;
    else if (inf_a)                           spv = a;
    else if (inf_b)                           spv = b;
    else begin
      sp  = 1'b0;
      spv = FP_ZERO;
    end
    if (b[30:0] > a[30:0]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    eb_eff  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es_eff  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d       = eb_eff - es_eff;
    xa      = {big[30:23] != 8'd0, big[22:0], 3'b000};
    yb      = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
    if (d >= 8'd27) begin
      ysh     = '0;
      ysticky = (yb != '0);
    end else begin
      ysh     = yb >> d;
      ysticky = ((yb & ~({27{1'b1}} << d)) != '0);
    end
  end

  logic [26:0] x1_r, y1_r;
  logic [7:0]  e1_r, e2_r;
  logic        sub1_r, sgn1_r, sp1_r, sub2_r, sgn2_r, sp2_r;
  logic [31:0] spv1_r, spv2_r;

  always_ff @(posedge clk) begin
    x1_r   <= xa;
    y1_r   <= ysh | 27'(ysticky);
    e1_r   <= eb_eff;
    sub1_r <= big[31] ^ sml[31];
    sgn1_r <= big[31];
    sp1_r  <= sp;
    spv1_r <= spv;
  end

  // stage 2: add or subtract, count leading zeros
  logic [27:0] s_nxt, s2_r;
  logic [4:0]  lz_nxt, lz2_r;

  always_comb begin
    s_nxt  = sub1_r ? ({1'b0, x1_r} - {1'b0, y1_r}) : ({1'b0, x1_r} + {1'b0, y1_r});
    lz_nxt = 5'd28;
    for (int i = 0; i < 28; i++) begin
      if (s_nxt[i]) lz_nxt = 5'(27 - i);
    end
  end

  always_ff @(posedge clk) begin
    s2_r   <= s_nxt;
    lz2_r  <= lz_nxt;
    e2_r   <= e1_r;
    sub2_r <= sub1_r;
    sgn2_r <= sgn1_r;
    sp2_r  <= sp1_r;
    spv2_r <= spv1_r;
  end

  // stage 3: normalise and round to nearest even
  logic [26:0] n27;
  logic [27:0] nsh;
  logic [8:0]  ex;
  logic [4:0]  sh;
  logic        st_r1, g, st, up;
  logic [7:0]  efld;
  logic [30:0] rnd;
  logic [31:0] y_nxt, y_r;

  always_comb begin
    st_r1 = 1'b0;
    sh    = '0;
    nsh   = s2_r;
    if (s2_r[27]) begin
      n27   = s2_r[27:1];
      st_r1 = s2_r[0];
      ex    = {1'b0, e2_r} + 9'd1;
    end else begin
      sh    = (5'(lz2_r - 5'd1) < 5'(e2_r - 8'd1) || e2_r > 8'd28) ?
              5'(lz2_r - 5'd1) : 5'(e2_r - 8'd1);
      nsh   = s2_r << sh;
      n27   = nsh[26:0];
      ex    = {1'b0, e2_r} - 9'(sh);
    end
    efld = n27[26] ? ex[7:0] : 8'd0;
    g    = n27[2];
    st   = n27[1] | n27[0] | st_r1;
    up   = g & (st | n27[3]);
    rnd  = {efld, n27[25:3]} + 31'(up);
    priority if (sp2_r)        y_nxt = spv2_r;
    else if (s2_r == '0)       y_nxt = {sgn2_r & ~sub2_r, 31'd0};
    else if (ex >= 9'd255)     y_nxt = {sgn2_r, 8'hFF, 23'd0};
    else                       y_nxt = {sgn2_r, rnd};
  end

  always_ff @(posedge clk) begin
    y_r <= y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign done = v3_r;
  assign y    = y_r;

endmodule

@@ rtl/core/spmv_back.sv @@
`timescale 1ns / 1ps
module spmv_back #(
  parameter int MAX_NONZEROS = spmv_pkg::DEF_MAX_NONZEROS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  spmv_pkg::spmv_cmd_t  q_head,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output spmv_pkg::spmv_out_t  out_word
);
  import spmv_pkg::*;

  localparam int NZ_CW = $clog2(MAX_NONZEROS + 1);
  localparam int NZ_AW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;

  back_state_t      state_r, state_nxt;
  spmv_cmd_t        cur_r, cur_nxt;
  logic [NZ_CW-1:0] cnt_r, cnt_nxt, start_r, start_nxt, end_r, end_nxt, e_r, e_nxt;
  logic [ROW_W:0]   scan_r, scan_nxt;
  logic             phase_r, phase_nxt;
  logic [VAL_W-1:0] dot_r, dot_nxt;
  spmv_out_t        res_r, res_nxt, out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SEEN_WORDS-1:0] seen_vld_r, seen_vld_nxt;

  // storage
  logic [VAL_W-1:0]  nz_val_mem [MAX_NONZEROS];
  logic [COL_W-1:0]  nz_col_mem [MAX_NONZEROS];
  logic [VAL_W-1:0]  x_mem      [COLS];
  logic [VAL_W-1:0]  y_mem      [ROWS];
  logic [NZ_CW-1:0]  rs_mem     [ROWS];
  logic [SEEN_W-1:0] seen_mem   [SEEN_WORDS];

  logic [VAL_W-1:0]   nz_val_q, x_q, y_q;
  logic [COL_W-1:0]   nz_col_q;
  logic [NZ_CW-1:0]   rs_q;
  logic [SEEN_W-1:0]  seen_q;

  logic               nz_we, x_we, y_we, rs_we, seen_we;
  logic [SEEN_AW-1:0] seen_raddr, scan_w, seen_ra_r;
  logic [ROW_W-1:0]   rs_raddr;
  logic [SEEN_W-1:0]  seen_word, seen_hit;
  logic [SEEN_BW-1:0] hit_pos;

  logic               mul_start, mul_done, add_start, add_done;
  logic [VAL_W-1:0]   mul_y, add_a, add_b, add_y;
  logic               bound_take;
  logic [NZ_CW-1:0]   bound_v;

  assign scan_w     = scan_r[ROW_W-1:SEEN_BW];
  assign seen_raddr = (state_r == ST_EXEC) ? cur_r.row_index[ROW_W-1:SEEN_BW] : scan_w;

  always_ff @(posedge clk) begin
    if (nz_we) begin
      nz_val_mem[cnt_r[NZ_AW-1:0]] <= cur_r.entry_value;
      nz_col_mem[cnt_r[NZ_AW-1:0]] <= cur_r.column_index;
    end
    nz_val_q <= nz_val_mem[e_r[NZ_AW-1:0]];
    nz_col_q <= nz_col_mem[e_r[NZ_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (x_we) x_mem[cur_r.column_index] <= cur_r.entry_value;
    x_q <= x_mem[nz_col_q];
  end

  always_ff @(posedge clk) begin
    if (y_we) y_mem[cur_r.row_index] <= cur_r.entry_value;
    y_q <= y_mem[cur_r.row_index];
  end

  always_ff @(posedge clk) begin
    if (rs_we) rs_mem[cur_r.row_index] <= cnt_r - 1'b1;
    rs_q <= rs_mem[rs_raddr];
  end

  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[cur_r.row_index[ROW_W-1:SEEN_BW]] <=
        seen_word | (SEEN_W'(1) << cur_r.row_index[SEEN_BW-1:0]);
    end
    seen_q    <= seen_mem[seen_raddr];
    seen_ra_r <= seen_raddr;
  end

  // lowest seen row at or after the scan position within the current word
  always_comb begin
    seen_word = seen_vld_r[seen_ra_r] ? seen_q : '0;
    seen_hit  = seen_word & ({SEEN_W{1'b1}} << scan_r[SEEN_BW-1:0]);
    hit_pos   = '0;
    for (int i = SEEN_W - 1; i >= 0; i--) begin
      if (seen_hit[i]) hit_pos = SEEN_BW'(i);
    end
    rs_raddr = {scan_w, hit_pos};
  end

  spmv_fpmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (nz_val_q),
    .b     (x_q),
    .done  (mul_done),
    .y     (mul_y)
  );

  spmv_fpadd u_add (
    .clk   (clk),
    .rst_n (rst_n),
    .start (add_start),
    .a     (add_a),
    .b     (add_b),
    .done  (add_done),
    .y     (add_y)
  );

  assign mul_start = (state_r == ST_X_RD);
  assign add_start = (state_r == ST_Y_RD) || ((state_r == ST_MUL_WAIT) && mul_done);
  assign add_a     = (state_r == ST_Y_RD) ? y_q : dot_r;
  assign add_b     = (state_r == ST_Y_RD) ? dot_r : mul_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      seen_vld_r  <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      seen_vld_r  <= seen_vld_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    start_r <= start_nxt;
    end_r   <= end_nxt;
    e_r     <= e_nxt;
    scan_r  <= scan_nxt;
    dot_r   <= dot_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    e_nxt         = e_r;
    scan_nxt      = scan_r;
    phase_nxt     = phase_r;
    dot_nxt       = dot_r;
    res_nxt       = res_r;
    seen_vld_nxt  = seen_vld_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !pop;
    q_pop         = 1'b0;
    nz_we         = 1'b0;
    x_we          = 1'b0;
    y_we          = 1'b0;
    rs_we         = 1'b0;
    seen_we       = 1'b0;
    bound_take    = 1'b0;
    bound_v       = cnt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_head;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        unique case (cur_r.op)
          OP_CLEAR: begin
            cnt_nxt      = '0;
            seen_vld_nxt = '0;
          end
          OP_LDX: x_we = 1'b1;
          OP_LDY: y_we = 1'b1;
          OP_BAD: begin
            res_nxt   = '{result_row: cur_r.row_index, result_value: FP_ZERO,
                          bad_request: 1'b1};
            state_nxt = ST_EMIT;
          end
          OP_NZ: begin
            if (cnt_r >= NZ_CW'(MAX_NONZEROS)) begin
              res_nxt   = '{result_row: cur_r.row_index, result_value: FP_ZERO,
                            bad_request: 1'b1};
              state_nxt = ST_EMIT;
            end else begin
              nz_we     = 1'b1;
              cnt_nxt   = cnt_r + 1'b1;
              state_nxt = ST_NZ_SEEN;
            end
          end
          OP_ROW: begin
            scan_nxt  = {1'b0, cur_r.row_index};
            phase_nxt = 1'b0;
            dot_nxt   = FP_ZERO;
            state_nxt = ST_SCAN_RD;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_NZ_SEEN: begin
        // first entry of a row records its start
        if (!seen_word[cur_r.row_index[SEEN_BW-1:0]]) begin
          rs_we   = 1'b1;
          seen_we = 1'b1;
          seen_vld_nxt[cur_r.row_index[ROW_W-1:SEEN_BW]] = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_SCAN_RD: begin
        if (scan_r[ROW_W]) begin
          bound_take = 1'b1;
        end else begin
          state_nxt = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (seen_hit != '0) begin
          state_nxt = ST_START_GOT;
        end else if (scan_w == {SEEN_AW{1'b1}}) begin
          bound_take = 1'b1;
        end else begin
          scan_nxt  = {1'b0, scan_w + 1'b1, {SEEN_BW{1'b0}}};
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_START_GOT: begin
        bound_take = 1'b1;
        bound_v    = rs_q;
      end
      ST_ELEM_CHK: begin
        state_nxt = (e_r < end_r) ? ST_ELEM_RD : ST_Y_RD;
      end
      ST_ELEM_RD:  state_nxt = ST_X_RD;
      ST_X_RD:     state_nxt = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) state_nxt = ST_ADD_WAIT;
      end
      ST_ADD_WAIT: begin
        if (add_done) begin
          dot_nxt   = add_y;
          e_nxt     = e_r + 1'b1;
          state_nxt = ST_ELEM_CHK;
        end
      end
      ST_Y_RD: state_nxt = ST_SUM_WAIT;
      ST_SUM_WAIT: begin
        if (add_done) begin
          res_nxt   = '{result_row: cur_r.row_index, result_value: add_y,
                        bad_request: 1'b0};
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // a row boundary is known: first the start, then the end
    if (bound_take) begin
      if (!phase_r) begin
        start_nxt = bound_v;
        phase_nxt = 1'b1;
        scan_nxt  = {1'b0, cur_r.row_index} + 1'b1;
        state_nxt = ST_SCAN_RD;
      end else begin
        end_nxt   = (bound_v < cnt_r) ? bound_v : cnt_r;
        e_nxt     = start_r;
        state_nxt = ST_ELEM_CHK;
      end
    end
  end

  assign empty    = !out_valid_r;
  assign out_word = out_r;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import spmv_pkg::*;

  localparam int MAXNZ      = DEF_MAX_NONZEROS;
  localparam int IDLE_WAIT  = 64;      // drain allowance for queued loads
  localparam int STALL_CAP  = 200000;  // cycles with no word moving

  logic             clk;
  logic             rst_n;
  logic             push;
  logic             full;
  spmv_in_t         in_word;
  logic             empty;
  logic             pop;
  spmv_out_t        out_word;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  csr_sparse_matrix_vector_multiply_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the matrix store, vectors and registers
  logic [VAL_W-1:0] nz_val [MAXNZ];
  int               nz_col [MAXNZ];
  int               row_first [ROWS+1];
  bit               row_seen [ROWS];
  logic [VAL_W-1:0] x_mem [COLS];
  logic [VAL_W-1:0] y_mem [ROWS];
  int               nz_count;
  int               row_reg;
  int               col_reg;

  spmv_in_t  pending_words [$];
  spmv_out_t expected_results [$];

  int  errors;
  int  send_idle;   // percentage of cycles the sender holds back
  int  recv_idle;   // percentage of cycles the receiver holds back
  int  stall_count;

  // Generator-side bookkeeping: which vector elements hold a written value,
  // and the effective limits of the current phase.
  bit  x_loaded [COLS];
  bit  y_loaded [ROWS];
  int  gen_rows;
  int  gen_cols;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Single precision helpers: widen exactly to double, round back to
  // nearest-even. Products of two singles are exact in double, and sums
  // rounded twice (double then single) give the single result.
  // ---------------------------------------------------------------------
  function automatic real single_to_real(logic [31:0] b);
    logic [10:0] e64;
    if (b[30:23] == 8'd0) begin
      if (b[22:0] == 23'd0) return $bitstoreal({b[31], 63'd0});
      return (b[31] ? -1.0 : 1.0) * real'(b[22:0]) * (2.0 ** -149);
    end
    e64 = 11'(int'(b[30:23]) - 127 + 1023);
    return $bitstoreal({b[31], e64, b[22:0], 29'd0});
  endfunction

  function automatic logic [31:0] real_to_single(real v);
    logic [63:0] d;
    logic [63:0] sig, q, rem, half, base;
    int          fe, sh;
    bit          up;
    d = $realtobits(v);
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    fe = int'(d[62:52]) - 1023 + 127;
    if (fe >= 255) return {d[63], 8'hFF, 23'd0};
    sig = {11'd0, 1'b1, d[51:0]};
    sh  = (fe >= 1) ? 29 : 30 - fe;
    if (sh > 54) return {d[63], 31'd0};
    q    = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    up   = (rem > half) || (rem == half && q[0]);
    base = (fe >= 1) ? ((64'(fe) << 23) + (q & 64'h7F_FFFF)) : q;
    base = base + 64'(up);
    return {d[63], base[30:0]};
  endfunction

  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    return real_to_single(single_to_real(a) * single_to_real(b));
  endfunction

  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    return real_to_single(single_to_real(a) + single_to_real(b));
  endfunction

  // Row start: first seen row at or after r, else the nonzero count
  function automatic int row_begin(int r);
    for (int k = r; k < ROWS; k++)
      if (row_seen[k]) return row_first[k];
    return nz_count;
  endfunction

  function automatic void clear_matrix();
    nz_count = 0;
    foreach (row_seen[i]) row_seen[i] = 1'b0;
    foreach (row_first[i]) row_first[i] = 0;
  endfunction

  // Apply one accepted word to the shadow state; returns 1 with the
  // expected result when the word produces one.
  function automatic bit spmv_apply(spmv_in_t w, output spmv_out_t res);
    int          rows_e, cols_e, first, last;
    logic [31:0] dot;
    rows_e = (row_reg > ROWS) ? ROWS : row_reg;
    cols_e = (col_reg > COLS) ? COLS : col_reg;
    res = '0;
    res.result_row = w.row_index;
    case (w.cmd)
      CMD_CLEAR: begin
        clear_matrix();
        return 1'b0;
      end
      CMD_LOAD_NZ: begin
        if (nz_count >= MAXNZ || int'(w.row_index) >= rows_e ||
            int'(w.column_index) >= cols_e) begin
          res.bad_request = 1'b1;
          return 1'b1;
        end
        nz_val[nz_count] = w.entry_value;
        nz_col[nz_count] = int'(w.column_index);
        if (!row_seen[w.row_index]) begin
          row_seen[w.row_index]  = 1'b1;
          row_first[w.row_index] = nz_count;
        end
        nz_count++;
        row_first[ROWS] = nz_count;
        return 1'b0;
      end
      CMD_LOAD_X: begin
        if (int'(w.column_index) < cols_e) x_mem[w.column_index] = w.entry_value;
        return 1'b0;
      end
      CMD_LOAD_Y: begin
        if (int'(w.row_index) < rows_e) y_mem[w.row_index] = w.entry_value;
        return 1'b0;
      end
      CMD_COMPUTE: begin
        if (int'(w.row_index) >= rows_e) begin
          res.bad_request = 1'b1;
          return 1'b1;
        end
        first = row_begin(int'(w.row_index));
        last  = row_begin(int'(w.row_index) + 1);
        if (last > nz_count) last = nz_count;
        dot = FP_ZERO;
        for (int e = first; e < last; e++)
          dot = fadd(dot, fmul(nz_val[e], x_mem[nz_col[e]]));
        res.result_value = fadd(y_mem[w.row_index], dot);
        return 1'b1;
      end
      default: return 1'b0;   // spare command codes do nothing
    endcase
  endfunction

  task automatic report(string what);
    $display("mismatch @%0t: %s", $realtime, what);
    errors++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: accept on push & !full, then offer the next pending word or
  // drop push for an idle cycle. One assignment to push per edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    spmv_out_t res;
    bit        next_push;
    if (!rst_n) begin
      push    <= 1'b0;
      in_word <= '0;
    end else begin
      next_push = push;
      if (push && !full) begin
        if (spmv_apply(in_word, res)) expected_results.push_back(res);
        next_push = 1'b0;
      end
      if (!next_push && pending_words.size() != 0 &&
          $urandom_range(0, 99) >= send_idle) begin
        next_push = 1'b1;
        in_word <= pending_words.pop_front();
      end
      push <= next_push;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each popped word with the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    spmv_out_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result row %0d", out_word.result_row));
        end else begin
          want = expected_results.pop_front();
          if (out_word.result_row !== want.result_row)
            report($sformatf("result_row %0d, want %0d",
                             out_word.result_row, want.result_row));
          if (out_word.result_value !== want.result_value)
            report($sformatf("row %0d result_value %h, want %h", want.result_row,
                             out_word.result_value, want.result_value));
          if (out_word.bad_request !== want.bad_request)
            report($sformatf("row %0d bad_request %b, want %b", want.result_row,
                             out_word.bad_request, want.bad_request));
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Watchdog: count cycles with work outstanding but no word moving
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) ||
        (pending_words.size() == 0 && expected_results.size() == 0 && !push)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  // Finite, normal values with exponents kept well away from overflow and
  // from the subnormal range, so products and sums stay ordinary numbers.
  function automatic logic [31:0] fp_value();
    if ($urandom_range(0, 15) == 0) return FP_ZERO;
    return {1'($urandom_range(0, 1)), 8'($urandom_range(100, 154)), 23'($urandom)};
  endfunction

  function automatic spmv_in_t make_word(logic [2:0] c, int r, int col,
                                         logic [31:0] v);
    spmv_in_t w;
    w.cmd          = c;
    w.row_index    = ROW_W'(r);
    w.column_index = COL_W'(col);
    w.entry_value  = v;
    return w;
  endfunction

  // Queue one word; first load any x or y element it would read unwritten.
  task automatic add_word(logic [2:0] c, int r, int col, logic [31:0] v);
    if (c == CMD_LOAD_NZ && r < gen_rows && col < gen_cols && !x_loaded[col])
      add_word(CMD_LOAD_X, 0, col, fp_value());
    if (c == CMD_COMPUTE && r < gen_rows && !y_loaded[r])
      add_word(CMD_LOAD_Y, r, 0, fp_value());
    if (c == CMD_LOAD_X && col < gen_cols) x_loaded[col] = 1'b1;
    if (c == CMD_LOAD_Y && r < gen_rows) y_loaded[r] = 1'b1;
    pending_words.push_back(make_word(c, r, col, v));
  endtask

  // Hold until the block has drained everything, then allow queued loads
  // to finish inside the engine.
  task automatic wait_idle();
    while (pending_words.size() != 0 || push || expected_results.size() != 0)
      @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    if (idx == REG_ROW_COUNT) row_reg = value;
    else col_reg = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_limits(int rows_v, int cols_v);
    write_reg(REG_ROW_COUNT, rows_v);
    write_reg(REG_COLUMN_COUNT, cols_v);
    gen_rows = (rows_v > ROWS) ? ROWS : rows_v;
    gen_cols = (cols_v > COLS) ? COLS : cols_v;
  endtask

  // A well-formed matrix: usually a clear, rows in ascending order with a few
  // entries each, then compute requests mostly on rows in range.
  task automatic gen_matrix();
    int r, n;
    if ($urandom_range(0, 3) != 0) add_word(CMD_CLEAR, 0, 0, FP_ZERO);
    r = $urandom_range(0, gen_rows - 1);
    n = $urandom_range(1, 8);
    for (int k = 0; k < n && r < gen_rows; k++) begin
      for (int j = $urandom_range(1, 4); j > 0; j--)
        add_word(CMD_LOAD_NZ, r, $urandom_range(0, gen_cols - 1), fp_value());
      r += $urandom_range(1, 6);
    end
    for (int k = $urandom_range(2, 6); k > 0; k--)
      if ($urandom_range(0, 7) == 0)
        add_word(CMD_COMPUTE, $urandom_range(0, 1023), 0, FP_ZERO);
      else
        add_word(CMD_COMPUTE, $urandom_range(0, gen_rows - 1), 0, FP_ZERO);
  endtask

  // Noise: any command, any fields, small indexes favoured.
  task automatic gen_noise();
    int r, col;
    r   = $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 7);
    col = $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 7);
    add_word(3'($urandom_range(0, 7)), r, col, fp_value());
  endtask

  task automatic gen_random(int items);
    int target;
    target = pending_words.size() + items;
    while (pending_words.size() < target)
      if ($urandom_range(0, 3) == 0) gen_noise();
      else gen_matrix();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    errors    = 0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_ROW_COUNT;
    cfg_data  = '0;
    push      = 1'b0;
    pop       = 1'b0;
    in_word   = '0;
    send_idle = 23;
    recv_idle = 70;
    row_reg   = int'(ROW_COUNT_RST);
    col_reg   = int'(COLUMN_COUNT_RST);
    clear_matrix();
    foreach (x_mem[i]) x_mem[i] = FP_ZERO;
    foreach (y_mem[i]) y_mem[i] = FP_ZERO;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: full size, directed corners first
    set_limits(1024, 1024);
    add_word(CMD_LOAD_X, 0, 1023, fp_value());
    add_word(CMD_LOAD_NZ, 0, 0, fp_value());
    add_word(CMD_LOAD_NZ, 0, 1023, fp_value());
    add_word(CMD_LOAD_NZ, 3, 5, fp_value());
    add_word(CMD_LOAD_NZ, 5, 0, fp_value());
    add_word(CMD_LOAD_NZ, 3, 1, fp_value());     // row revisited out of order
    add_word(CMD_LOAD_NZ, 1023, 1023, FP_ZERO);
    add_word(CMD_COMPUTE, 0, 0, FP_ZERO);
    add_word(CMD_COMPUTE, 3, 0, FP_ZERO);
    add_word(CMD_COMPUTE, 5, 0, FP_ZERO);
    add_word(CMD_COMPUTE, 7, 0, FP_ZERO);        // empty row between seen rows
    add_word(CMD_COMPUTE, 1023, 0, FP_ZERO);
    add_word(3'd5, 1023, 1023, fp_value());      // spare codes are ignored
    add_word(3'd6, 0, 0, fp_value());
    add_word(3'd7, 512, 512, fp_value());
    add_word(CMD_CLEAR, 0, 0, FP_ZERO);
    add_word(CMD_COMPUTE, 0, 0, FP_ZERO);        // empty matrix: y alone
    add_word(CMD_LOAD_NZ, 900, 2, fp_value());
    add_word(CMD_COMPUTE, 1023, 0, FP_ZERO);     // trailing empty row
    add_word(CMD_COMPUTE, 899, 0, FP_ZERO);
    // Pause the sender until every result is home
    wait_idle();
    gen_random(250);
    wait_idle();

    // Phase two: smallest sizes, receiver now fast and sender slow
    send_idle = 70;
    recv_idle = 23;
    set_limits(1, 1);
    add_word(CMD_LOAD_X, 0, 5, 32'hFFFF_FFFF);   // out of range, ignored
    add_word(CMD_LOAD_Y, 9, 0, 32'hFFFF_FFFF);
    add_word(CMD_LOAD_NZ, 1, 0, fp_value());     // row out of range
    add_word(CMD_LOAD_NZ, 0, 1, fp_value());     // column out of range
    add_word(CMD_LOAD_NZ, 0, 0, fp_value());
    add_word(CMD_COMPUTE, 0, 0, FP_ZERO);
    add_word(CMD_COMPUTE, 1023, 0, FP_ZERO);
    gen_random(100);
    wait_idle();

    // Phase three: fill wide, then shrink rows without clearing
    add_word(CMD_CLEAR, 0, 0, FP_ZERO);
    wait_idle();
    set_limits(1024, 1024);
    for (int r = 50; r < 1000; r += 97)
      add_word(CMD_LOAD_NZ, r, $urandom_range(0, 1023), fp_value());
    wait_idle();
    set_limits(100, 200);
    add_word(CMD_COMPUTE, 50, 0, FP_ZERO);
    add_word(CMD_COMPUTE, 500, 0, FP_ZERO);
    add_word(CMD_LOAD_NZ, 200, 3, fp_value());
    gen_random(150);
    wait_idle();

    // Phase four: no idling; oversized register values; a dense band of rows
    send_idle = 0;
    recv_idle = 0;
    set_limits(2047, 1500);
    add_word(CMD_CLEAR, 0, 0, FP_ZERO);
    for (int r = 0; r < 64; r++)
      for (int j = 0; j < 2; j++)
        add_word(CMD_LOAD_NZ, r, $urandom_range(0, 15), fp_value());
    add_word(CMD_LOAD_NZ, 1023, 0, fp_value());  // last row
    add_word(CMD_LOAD_NZ, 0, 0, fp_value());
    add_word(CMD_COMPUTE, 1023, 0, FP_ZERO);
    for (int k = 0; k < 20; k++)
      add_word(CMD_COMPUTE, $urandom_range(0, 1023), 0, FP_ZERO);
    gen_random(250);
    wait_idle();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
